// File: hw/rtl/buffer_slot_lease_allocator_unit_assert.svh
// ----------------------------------------------------------------------------
// buffer slot lease allocator assertion macros
// shared property wrappers, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef BUFFER_SLOT_LEASE_ALLOCATOR_UNIT_ASSERT_SVH
`define BUFFER_SLOT_LEASE_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BSLA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bsla_pkg.sv
// ----------------------------------------------------------------------------
// bsla_pkg
// types and constants shared by the buffer slot lease allocator
// ----------------------------------------------------------------------------
package bsla_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = 4;
  localparam int CNT_W      = 5;
  localparam int BYTES_W    = 40;
  localparam int QID_W      = 8;
  localparam int CFG_IDX_W  = 2;

  // status codes
  localparam logic [2:0] ST_REUSED   = 3'd0;
  localparam logic [2:0] ST_SIZED    = 3'd1;
  localparam logic [2:0] ST_ZERO     = 3'd2;
  localparam logic [2:0] ST_QLIMIT   = 3'd3;
  localparam logic [2:0] ST_NOSLOT   = 3'd4;
  localparam logic [2:0] ST_RELEASED = 3'd5;
  localparam logic [2:0] ST_IDLE     = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLOTS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ALLOC   = 2'd2;

  localparam logic [CNT_W-1:0]   MAX_SLOTS_RST = 5'd4;
  localparam logic [CNT_W-1:0]   QLIMIT_RST    = 5'd0;
  localparam logic [BYTES_W-1:0] MIN_ALLOC_RST = 40'd67108864;

  typedef enum logic {
    MODE_ACQUIRE = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_t;

  typedef struct packed {
    logic               mode;
    logic [BYTES_W-1:0] required_bytes;
    logic [QID_W-1:0]   queue_id;
    logic [SLOT_W-1:0]  release_slot;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [SLOT_W-1:0]  granted_slot;
    logic [BYTES_W-1:0] slot_capacity;
  } out_item_t;

  // request packet travelling down the cell chain
  typedef struct packed {
    logic               valid;
    logic               mode;
    logic [BYTES_W-1:0] bytes;
    logic [QID_W-1:0]   qid;
    logic [SLOT_W-1:0]  rel;
    logic [CNT_W-1:0]   n;
    logic [CNT_W-1:0]   cnt;
    logic               fit;
    logic [SLOT_W-1:0]  fit_idx;
    logic [BYTES_W-1:0] fit_size;
    logic               free;
    logic [SLOT_W-1:0]  free_idx;
    logic               rel_busy;
    logic [BYTES_W-1:0] rel_size;
  } scan_t;

  // slot update broadcast to all cells
  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  idx;
    logic               busy;
    logic [QID_W-1:0]   qid;
    logic               set_size;
    logic [BYTES_W-1:0] size;
  } wr_t;

endpackage

// File: hw/rtl/bsla_cell.sv
// ----------------------------------------------------------------------------
// bsla_cell
// one buffer slot: holds busy mark, capacity and owner queue, and folds its
// contribution into the request packet passing through
// ----------------------------------------------------------------------------
module bsla_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bsla_pkg::SLOT_W-1:0] cell_idx,
  input  bsla_pkg::scan_t             scan_in,
  input  bsla_pkg::wr_t               wr,
  output bsla_pkg::scan_t             scan_out
);
  import bsla_pkg::*;

  logic               busy_r;
  logic [BYTES_W-1:0] size_r;
  logic [QID_W-1:0]   queue_r;
  scan_t              scan_r;
  scan_t              scan_nxt;
  logic               live;
  logic               idle_slot;

  // slot exists and is free
  assign live      = {1'b0, cell_idx} < scan_in.n;
  assign idle_slot = live && !busy_r;

  // fold this slot into the packet
  always_comb begin
    scan_nxt = scan_in;
    if (live && busy_r && queue_r == scan_in.qid) begin
      scan_nxt.cnt = scan_in.cnt + 1'b1;
    end
    if (!scan_in.fit && idle_slot && size_r >= scan_in.bytes) begin
      scan_nxt.fit      = 1'b1;
      scan_nxt.fit_idx  = cell_idx;
      scan_nxt.fit_size = size_r;
    end
    if (!scan_in.free && idle_slot) begin
      scan_nxt.free     = 1'b1;
      scan_nxt.free_idx = cell_idx;
    end
    if (cell_idx == scan_in.rel) begin
      scan_nxt.rel_busy = busy_r;
      scan_nxt.rel_size = size_r;
    end
  end

  // slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      size_r  <= '0;
      queue_r <= '0;
    end else if (wr.en && wr.idx == cell_idx) begin
      busy_r  <= wr.busy;
      queue_r <= wr.qid;
      if (wr.set_size) begin
        size_r <= wr.size;
      end
    end
  end

  // hand packet to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r.valid <= 1'b0;
    end else begin
      scan_r <= scan_nxt;
    end
  end

  assign scan_out = scan_r;

endmodule

// File: hw/rtl/bsla_ctrl.sv
// ----------------------------------------------------------------------------
// bsla_ctrl
// request sequencer: configuration, launch of the scan packet, final
// decision, slot update and result register
// ----------------------------------------------------------------------------
module bsla_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bsla_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bsla_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bsla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsla_pkg::BYTES_W-1:0]   cfg_data,
  output bsla_pkg::scan_t                head,
  input  bsla_pkg::scan_t                tail,
  output bsla_pkg::wr_t                  wr
);
  import bsla_pkg::*;

  `include "buffer_slot_lease_allocator_unit_assert.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   max_slots_r;
  logic [CNT_W-1:0]   qlimit_r;
  logic [BYTES_W-1:0] min_alloc_r;
  logic [CNT_W-1:0]   created_r;
  logic [CNT_W-1:0]   created_nxt;
  scan_t              head_r;
  scan_t              head_nxt;
  scan_t              tail_r;
  logic               out_valid_r;
  out_item_t          out_data_r;
  out_item_t          res;
  wr_t                wr_nxt;
  logic [CNT_W-1:0]   cap;
  logic [BYTES_W-1:0] new_size;
  logic               accept;
  logic               out_free;
  logic               finish;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign finish    = (state_r == S_DONE) && out_free;

  // effective slot limit, clamped to 1..SLOT_COUNT
  always_comb begin
    if (max_slots_r == '0) begin
      cap = CNT_W'(1);
    end else if (max_slots_r > CNT_W'(SLOT_COUNT)) begin
      cap = CNT_W'(SLOT_COUNT);
    end else begin
      cap = max_slots_r;
    end
  end

  assign new_size = (tail_r.bytes > min_alloc_r) ? tail_r.bytes : min_alloc_r;

  // packet launched into the first cell on acceptance
  always_comb begin
    head_nxt       = '0;
    head_nxt.valid = accept;
    head_nxt.mode  = in_data.mode;
    head_nxt.bytes = in_data.required_bytes;
    head_nxt.qid   = in_data.queue_id;
    head_nxt.rel   = in_data.release_slot;
    head_nxt.n     = created_r;
  end

  // final decision from the packet that left the last cell
  always_comb begin
    res         = '0;
    wr_nxt      = '0;
    created_nxt = created_r;
    wr_nxt.qid  = tail_r.qid;
    if (tail_r.mode == MODE_RELEASE) begin
      res.granted_slot  = tail_r.rel;
      res.slot_capacity = tail_r.rel_size;
      if (tail_r.rel_busy) begin
        res.status  = ST_RELEASED;
        wr_nxt.en   = 1'b1;
        wr_nxt.idx  = tail_r.rel;
        wr_nxt.busy = 1'b0;
        wr_nxt.qid  = '0;
      end else begin
        res.status = ST_IDLE;
      end
    end else if (tail_r.bytes == '0) begin
      res.status = ST_ZERO;
    end else if (qlimit_r != '0 && tail_r.qid != '0 && tail_r.cnt >= qlimit_r) begin
      res.status = ST_QLIMIT;
    end else if (tail_r.fit) begin
      res.status        = ST_REUSED;
      res.granted_slot  = tail_r.fit_idx;
      res.slot_capacity = tail_r.fit_size;
      wr_nxt.en         = 1'b1;
      wr_nxt.idx        = tail_r.fit_idx;
      wr_nxt.busy       = 1'b1;
    end else if (tail_r.free || tail_r.n < cap) begin
      res.status        = ST_SIZED;
      res.slot_capacity = new_size;
      wr_nxt.en         = 1'b1;
      wr_nxt.busy       = 1'b1;
      wr_nxt.set_size   = 1'b1;
      wr_nxt.size       = new_size;
      if (tail_r.free) begin
        res.granted_slot = tail_r.free_idx;
        wr_nxt.idx       = tail_r.free_idx;
      end else begin
        res.granted_slot = tail_r.n[SLOT_W-1:0];
        wr_nxt.idx       = tail_r.n[SLOT_W-1:0];
        created_nxt      = tail_r.n + 1'b1;
      end
    end else begin
      res.status = ST_NOSLOT;
    end
    wr_nxt.en = wr_nxt.en && finish;
  end

  assign wr = wr_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_slots_r <= MAX_SLOTS_RST;
      qlimit_r    <= QLIMIT_RST;
      min_alloc_r <= MIN_ALLOC_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_SLOTS:   max_slots_r <= cfg_data[CNT_W-1:0];
        CFG_QUEUE_LIMIT: qlimit_r    <= cfg_data[CNT_W-1:0];
        CFG_MIN_ALLOC:   min_alloc_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, packet launch and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      created_r   <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      out_valid_r <= finish || (out_valid_r && out_stall);
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (tail.valid) begin
            tail_r  <= tail;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r <= res;
            created_r  <= created_nxt;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign head      = head_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `BSLA_ASSERT_NOW(a_tail_in_scan, tail.valid, state_r == S_SCAN, "packet left chain outside scan")
  `BSLA_ASSERT_NOW(a_created_bound, 1'b1, created_r <= CNT_W'(SLOT_COUNT), "slot count overflow")
  `BSLA_ASSERT_NEXT(a_created_step, 1'b1, created_r == $past(created_r) || created_r == $past(created_r) + 1'b1, "slot count jumped")
  `BSLA_ASSERT_NEXT(a_sized_min, finish && res.status == ST_SIZED, out_data_r.slot_capacity >= min_alloc_r, "sized slot below minimum")

endmodule

// File: hw/rtl/buffer_slot_lease_allocator_unit.sv
// ----------------------------------------------------------------------------
// buffer_slot_lease_allocator_unit
// first-fit lease allocator over a pool of sixteen buffer slots
// ----------------------------------------------------------------------------
// An accepted item is registered as the request packet at the head of the
// row of slot cells; each cell in turn registers it and adds its count,
// fit, free and release information. The packet leaving the last cell is
// captured; the controller then decides, updates the chosen slot and loads
// the result into the output register. The next item is accepted in the
// cycle after the decision; the decision waits only while the output
// register still holds an unaccepted result. A finished result may wait in
// the output register while the next item scans. The slot store is cleared
// by reset directly, with no clearing pass. Configuration writes are always
// ready and take effect in the next cycle.
module buffer_slot_lease_allocator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bsla_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bsla_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bsla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsla_pkg::BYTES_W-1:0]   cfg_data
);
  import bsla_pkg::*;

  scan_t chain [SLOT_COUNT+1];
  wr_t   wr;

  // sequencer
  bsla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (chain[0]),
    .tail      (chain[SLOT_COUNT]),
    .wr        (wr)
  );

  // row of slot cells, packet flows from slot 0 upward
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    bsla_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (SLOT_W'(i)),
      .scan_in  (chain[i]),
      .wr       (wr),
      .scan_out (chain[i+1])
    );
  end

endmodule
